// File: design/fcdt_pkg.sv
package fcdt_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned TIMER_COUNT = 5;
  localparam int unsigned CTRL_WIDTH  = 23;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned ADDR_WIDTH  = 7;
  localparam int unsigned IRQ_WIDTH   = TIMER_COUNT;
  localparam int unsigned WORD_WIDTH  = ADDR_WIDTH - 2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CTRL_WIDTH-1:0]  ctrl_t;
  typedef logic [WORD_WIDTH-1:0]  word_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Control word bit positions for each timer.
  localparam int unsigned START_BIT  [TIMER_COUNT] = '{0, 8, 12, 16, 20};
  localparam int unsigned MANUAL_BIT [TIMER_COUNT] = '{1, 9, 13, 17, 21};
  localparam int unsigned RELOAD_BIT [TIMER_COUNT] = '{3, 11, 15, 19, 22};

  // Register word indexes (byte offset divided by four).
  localparam word_t WORD_CTRL  = 5'd2;
  localparam word_t WORD_CNTB0 = 5'd3;
  localparam word_t WORD_CMPB0 = 5'd4;
  localparam word_t WORD_CNTO0 = 5'd5;
  localparam word_t WORD_CNTB1 = 5'd6;
  localparam word_t WORD_CMPB1 = 5'd7;
  localparam word_t WORD_CNTO1 = 5'd8;
  localparam word_t WORD_CNTB2 = 5'd9;
  localparam word_t WORD_CMPB2 = 5'd10;
  localparam word_t WORD_CNTO2 = 5'd11;
  localparam word_t WORD_CNTB3 = 5'd12;
  localparam word_t WORD_CMPB3 = 5'd13;
  localparam word_t WORD_CNTO3 = 5'd14;
  localparam word_t WORD_CNTB4 = 5'd15;
  localparam word_t WORD_CNTO4 = 5'd16;

endpackage

// File: design/five_channel_down_timer.sv
// Five-channel down-counting timer with a 32-bit register port.
// Input channel (in_valid/in_ready) carries one request per item: a timer
// tick, a register write or a register read, with a byte address and write
// data. Every request yields exactly one result on the output channel
// (out_valid/out_ready): read data for reads, and a five-bit interrupt
// pulse vector for ticks, with the other field zero.
// The register state is updated at the edge that accepts the request, and
// the result appears in the output register on the next cycle. One request
// per cycle is sustained while the receiver takes each result; all five
// counters update in parallel on a tick.
// When the receiver stalls, the result holds in the output register and
// in_ready falls until it is taken; in_ready is high whenever the output
// register is empty or being drained in the same cycle.
// Reset clears the control word, all buffers, all counters and the
// output register, so every timer starts stopped at zero.
module five_channel_down_timer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [fcdt_pkg::ADDR_WIDTH-1:0]      in_address,
  input  logic [fcdt_pkg::DATA_WIDTH-1:0]      in_write_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fcdt_pkg::DATA_WIDTH-1:0]      out_read_data,
  output logic [fcdt_pkg::IRQ_WIDTH-1:0]       out_irq_pulse
);

  fcdt_pkg::ctrl_t  control_r, control_nxt;
  fcdt_pkg::count_t cnt_buf_r [fcdt_pkg::TIMER_COUNT];
  fcdt_pkg::count_t cnt_buf_nxt [fcdt_pkg::TIMER_COUNT];
  fcdt_pkg::count_t cmp_buf_r [fcdt_pkg::TIMER_COUNT-1];
  fcdt_pkg::count_t cmp_buf_nxt [fcdt_pkg::TIMER_COUNT-1];
  fcdt_pkg::count_t counter_r [fcdt_pkg::TIMER_COUNT];
  fcdt_pkg::count_t counter_nxt [fcdt_pkg::TIMER_COUNT];

  logic                               out_valid_r, out_valid_nxt;
  logic [fcdt_pkg::DATA_WIDTH-1:0]    read_data_r, read_data_nxt;
  logic [fcdt_pkg::IRQ_WIDTH-1:0]     irq_r, irq_nxt;

  logic                               accept;
  fcdt_pkg::cmd_t                     cmd;
  fcdt_pkg::word_t                    word;
  logic                               aligned;
  fcdt_pkg::count_t                   wr_value;
  logic [fcdt_pkg::DATA_WIDTH-1:0]    rd_value;

  assign in_ready      = !out_valid_r || out_ready;
  assign accept        = in_valid && in_ready;
  assign cmd           = fcdt_pkg::cmd_t'(in_command);
  assign word          = in_address[fcdt_pkg::ADDR_WIDTH-1:2];
  assign aligned       = (in_address[1:0] == 2'b00);
  assign wr_value      = in_write_data[fcdt_pkg::COUNT_WIDTH-1:0];

  assign out_valid     = out_valid_r;
  assign out_read_data = read_data_r;
  assign out_irq_pulse = irq_r;

  // Register read decode; unaligned and unmapped offsets read as zero.
  always_comb begin
    rd_value = '0;
    if (aligned) begin
      unique case (word)
        fcdt_pkg::WORD_CTRL:  rd_value = fcdt_pkg::DATA_WIDTH'(control_r);
        fcdt_pkg::WORD_CNTB0: rd_value = fcdt_pkg::DATA_WIDTH'(cnt_buf_r[0]);
        fcdt_pkg::WORD_CMPB0: rd_value = fcdt_pkg::DATA_WIDTH'(cmp_buf_r[0]);
        fcdt_pkg::WORD_CNTO0: rd_value = fcdt_pkg::DATA_WIDTH'(counter_r[0]);
        fcdt_pkg::WORD_CNTB1: rd_value = fcdt_pkg::DATA_WIDTH'(cnt_buf_r[1]);
        fcdt_pkg::WORD_CMPB1: rd_value = fcdt_pkg::DATA_WIDTH'(cmp_buf_r[1]);
        fcdt_pkg::WORD_CNTO1: rd_value = fcdt_pkg::DATA_WIDTH'(counter_r[1]);
        fcdt_pkg::WORD_CNTB2: rd_value = fcdt_pkg::DATA_WIDTH'(cnt_buf_r[2]);
        fcdt_pkg::WORD_CMPB2: rd_value = fcdt_pkg::DATA_WIDTH'(cmp_buf_r[2]);
        fcdt_pkg::WORD_CNTO2: rd_value = fcdt_pkg::DATA_WIDTH'(counter_r[2]);
        fcdt_pkg::WORD_CNTB3: rd_value = fcdt_pkg::DATA_WIDTH'(cnt_buf_r[3]);
        fcdt_pkg::WORD_CMPB3: rd_value = fcdt_pkg::DATA_WIDTH'(cmp_buf_r[3]);
        fcdt_pkg::WORD_CNTO3: rd_value = fcdt_pkg::DATA_WIDTH'(counter_r[3]);
        fcdt_pkg::WORD_CNTB4: rd_value = fcdt_pkg::DATA_WIDTH'(cnt_buf_r[4]);
        fcdt_pkg::WORD_CNTO4: rd_value = fcdt_pkg::DATA_WIDTH'(counter_r[4]);
        default:              rd_value = '0;
      endcase
    end
  end

  always_comb begin
    control_nxt   = control_r;
    cnt_buf_nxt   = cnt_buf_r;
    cmp_buf_nxt   = cmp_buf_r;
    counter_nxt   = counter_r;
    read_data_nxt = read_data_r;
    irq_nxt       = irq_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
      read_data_nxt = '0;
      irq_nxt       = '0;
      unique case (cmd)
        fcdt_pkg::CMD_TICK: begin
          for (int k = 0; k < fcdt_pkg::TIMER_COUNT; k++) begin
            if (control_r[fcdt_pkg::START_BIT[k]]) begin
              // An expired counter reloads or stops instead of counting.
              if (counter_r[k] == '0) begin
                irq_nxt[k] = 1'b1;
                if (control_r[fcdt_pkg::RELOAD_BIT[k]]) begin
                  counter_nxt[k] = cnt_buf_r[k];
                end else begin
                  control_nxt[fcdt_pkg::START_BIT[k]] = 1'b0;
                end
              end else begin
                counter_nxt[k] = counter_r[k] - fcdt_pkg::COUNT_WIDTH'(1);
              end
            end
          end
        end
        fcdt_pkg::CMD_WRITE: begin
          if (aligned) begin
            unique case (word)
              fcdt_pkg::WORD_CTRL: begin
                control_nxt = in_write_data[fcdt_pkg::CTRL_WIDTH-1:0];
                for (int k = 0; k < fcdt_pkg::TIMER_COUNT; k++) begin
                  if (in_write_data[fcdt_pkg::MANUAL_BIT[k]]) begin
                    counter_nxt[k] = cnt_buf_r[k];
                  end
                end
              end
              fcdt_pkg::WORD_CNTB0: cnt_buf_nxt[0] = wr_value;
              fcdt_pkg::WORD_CMPB0: cmp_buf_nxt[0] = wr_value;
              fcdt_pkg::WORD_CNTB1: cnt_buf_nxt[1] = wr_value;
              fcdt_pkg::WORD_CMPB1: cmp_buf_nxt[1] = wr_value;
              fcdt_pkg::WORD_CNTB2: cnt_buf_nxt[2] = wr_value;
              fcdt_pkg::WORD_CMPB2: cmp_buf_nxt[2] = wr_value;
              fcdt_pkg::WORD_CNTB3: cnt_buf_nxt[3] = wr_value;
              fcdt_pkg::WORD_CMPB3: cmp_buf_nxt[3] = wr_value;
              fcdt_pkg::WORD_CNTB4: cnt_buf_nxt[4] = wr_value;
              default: ;
            endcase
          end
        end
        fcdt_pkg::CMD_READ: begin
          read_data_nxt = rd_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= '0;
      cnt_buf_r   <= '{default: '0};
      cmp_buf_r   <= '{default: '0};
      counter_r   <= '{default: '0};
      out_valid_r <= 1'b0;
      read_data_r <= '0;
      irq_r       <= '0;
    end else begin
      control_r   <= control_nxt;
      cnt_buf_r   <= cnt_buf_nxt;
      cmp_buf_r   <= cmp_buf_nxt;
      counter_r   <= counter_nxt;
      out_valid_r <= out_valid_nxt;
      read_data_r <= read_data_nxt;
      irq_r       <= irq_nxt;
    end
  end

endmodule

// File: design/fcdt_checker.sv
module fcdt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [1:0]                       in_command,
  input logic [fcdt_pkg::ADDR_WIDTH-1:0]  in_address,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [fcdt_pkg::DATA_WIDTH-1:0]  out_read_data,
  input logic [fcdt_pkg::IRQ_WIDTH-1:0]   out_irq_pulse
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_irq_pulse))
    else $error("result changed while stalled");

  // Every accepted request produces a result on the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // The block never refuses a request while its output register is empty.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Interrupt pulses and read data never appear in the same result.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_irq_pulse == '0) || (out_read_data == '0))
    else $error("interrupt and read data in one result");

  // An unaligned read returns zero.
  a_unaligned: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == fcdt_pkg::CMD_READ)
      && (in_address[1:0] != 2'b00) |=> out_read_data == '0)
    else $error("unaligned read returned data");

endmodule

bind five_channel_down_timer fcdt_checker u_fcdt_checker (.*);
